### rtl/rfx_pkg.sv
`default_nettype none

package rfx_pkg;

  // Word and field widths.
  localparam int FRAC_BITS_DEF = 16;
  localparam int WORD_W = 32;
  localparam int HR_W = 18;
  localparam int NRM_W = 18;
  localparam int ST_W = 2;
  // Wide enough for every exact intermediate before it is clipped to a word.
  localparam int SAT_W = 68;

  localparam logic [HR_W-1:0] HEAT_RATIO_RST = 18'd91750;

  // Status codes.
  localparam logic [ST_W-1:0] ST_OK  = 2'd0;
  localparam logic [ST_W-1:0] ST_BAD = 2'd1;
  localparam logic [ST_W-1:0] ST_SAT = 2'd2;

  typedef logic signed [WORD_W-1:0] word_t;
  typedef logic signed [NRM_W-1:0] nrm_t;

  typedef struct packed {
    word_t rho;
    word_t mx;
    word_t my;
    word_t e;
  } cell_t;

  typedef struct packed {
    cell_t own;
    cell_t nbr;
    nrm_t  nx;
    nrm_t  ny;
  } face_t;

  // What one side of the face hands to the flux stages.
  typedef struct packed {
    word_t p;
    word_t vn;
    word_t spd;
    logic  bad;
    logic  clip;
  } side_t;

  typedef struct packed {
    logic  clip;
    word_t val;
  } sat_t;

  // Clip a wide signed value to the signed word range.
  function automatic sat_t sat32(input logic signed [SAT_W-1:0] x);
    sat_t r;
    logic [SAT_W-WORD_W:0] hi;
    hi = x[SAT_W-1:WORD_W-1];
    r.clip = !((&hi) || !(|hi));
    if (!r.clip) begin
      r.val = x[WORD_W-1:0];
    end else if (x[SAT_W-1]) begin
      r.val = {1'b1, {(WORD_W-1){1'b0}}};
    end else begin
      r.val = {1'b0, {(WORD_W-1){1'b1}}};
    end
    return r;
  endfunction

  // Pipeline latencies, in clock edges.
  function automatic int div_lat(input int f);
    return WORD_W + f + 2;
  endfunction

  function automatic int sqrt_lat(input int f);
    return (WORD_W + f) / 2 + 1;
  endfunction

  function automatic int side_lat(input int f);
    return 2 * div_lat(f) + 8 + sqrt_lat(f);
  endfunction

  function automatic int unit_lat(input int f);
    return side_lat(f) + 5;
  endfunction

endpackage

`default_nettype wire

### rtl/rusanov_flux_2d_unit.sv
`default_nettype none

// Channel   Ports                                         Handshake
// input     own_*, nbr_*, normal_x, normal_y              start, busy
// config    heat_ratio_wdata                              heat_ratio_we
// result    flux_mass, flux_mom_x, flux_mom_y,            done
//           flux_energy, status
//
// One face is taken on every clock edge with start high and busy low.
// Its result is shown with done for one cycle. The result register is loaded
// after the input beat register, the two bit-per-stage dividers in series and
// the bit-per-stage square root on each side, and the flux stages.
// Busy is high through reset and drops at the first edge after it.
// Reset clears the valid bits and sets heat_ratio to 1.4. The receiver
// cannot stall, so the pipeline advances on every edge.
module rusanov_flux_2d_unit import rfx_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  output logic            busy,
  input  word_t           own_density,
  input  word_t           own_mom_x,
  input  word_t           own_mom_y,
  input  word_t           own_energy,
  input  word_t           nbr_density,
  input  word_t           nbr_mom_x,
  input  word_t           nbr_mom_y,
  input  word_t           nbr_energy,
  input  nrm_t            normal_x,
  input  nrm_t            normal_y,
  input  logic            heat_ratio_we,
  input  logic [HR_W-1:0] heat_ratio_wdata,
  output logic            done,
  output word_t           flux_mass,
  output word_t           flux_mom_x,
  output word_t           flux_mom_y,
  output word_t           flux_energy,
  output logic [ST_W-1:0] status
);

  localparam int SL = side_lat(FRAC_BITS);
  localparam int XW = WORD_W + 1;
  localparam int PW = XW + WORD_W;

  logic [HR_W-1:0] heat_ratio;
  logic vq [0:SL+3];
  face_t d [0:SL];
  side_t o_res, n_res;

  // Control: busy through reset, gamma register, valid bits.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b1;
      heat_ratio <= HEAT_RATIO_RST;
      for (int k = 0; k <= SL + 3; k++) begin
        vq[k] <= 1'b0;
      end
      done <= 1'b0;
    end else begin
      busy <= 1'b0;
      if (heat_ratio_we) begin
        heat_ratio <= heat_ratio_wdata;
      end
      vq[0] <= start && !busy;
      for (int k = 1; k <= SL + 3; k++) begin
        vq[k] <= vq[k-1];
      end
      done <= vq[SL+3];
    end
  end

  // Input beat register and state delay line.
  always_ff @(posedge clk) begin
    d[0] <= '{own: '{rho: own_density, mx: own_mom_x, my: own_mom_y, e: own_energy},
              nbr: '{rho: nbr_density, mx: nbr_mom_x, my: nbr_mom_y, e: nbr_energy},
              nx: normal_x, ny: normal_y};
    for (int k = 1; k <= SL; k++) begin
      d[k] <= d[k-1];
    end
  end

  rfx_side #(.FRAC_BITS(FRAC_BITS)) u_side_own (
    .clk        (clk),
    .side_in    (d[0].own),
    .nx         (d[0].nx),
    .ny         (d[0].ny),
    .heat_ratio (heat_ratio),
    .res        (o_res)
  );

  rfx_side #(.FRAC_BITS(FRAC_BITS)) u_side_nbr (
    .clk        (clk),
    .side_in    (d[0].nbr),
    .nx         (d[0].nx),
    .ny         (d[0].ny),
    .heat_ratio (heat_ratio),
    .res        (n_res)
  );

  // Flux stage 1: wave speed, pressure sum, jumps and per-lane operands.
  logic signed [XW-1:0] oa1 [0:3];
  logic signed [XW-1:0] na1 [0:3];
  logic signed [XW-1:0] jd1 [0:3];
  logic signed [XW-1:0] ps1;
  word_t r1, ovn1, nvn1;
  nrm_t nx1, ny1;
  logic bad1, clip1;
  face_t f0;

  assign f0 = d[SL];

  always_ff @(posedge clk) begin
    r1 <= ((o_res.spd > n_res.spd) ? o_res.spd : n_res.spd) >>> 1;
    ps1 <= XW'(o_res.p) + XW'(n_res.p);
    oa1[0] <= XW'(f0.own.rho);
    oa1[1] <= XW'(f0.own.mx);
    oa1[2] <= XW'(f0.own.my);
    oa1[3] <= XW'(f0.own.e) + XW'(o_res.p);
    na1[0] <= XW'(f0.nbr.rho);
    na1[1] <= XW'(f0.nbr.mx);
    na1[2] <= XW'(f0.nbr.my);
    na1[3] <= XW'(f0.nbr.e) + XW'(n_res.p);
    jd1[0] <= XW'(f0.own.rho) - XW'(f0.nbr.rho);
    jd1[1] <= XW'(f0.own.mx) - XW'(f0.nbr.mx);
    jd1[2] <= XW'(f0.own.my) - XW'(f0.nbr.my);
    jd1[3] <= XW'(f0.own.e) - XW'(f0.nbr.e);
    ovn1 <= o_res.vn;
    nvn1 <= n_res.vn;
    nx1 <= f0.nx;
    ny1 <= f0.ny;
    bad1 <= o_res.bad | n_res.bad;
    clip1 <= o_res.clip | n_res.clip;
  end

  // Flux stage 2: products.
  logic signed [PW-1:0] ma2 [0:3];
  logic signed [PW-1:0] mb2 [0:3];
  logic signed [PW-1:0] mc2 [0:3];
  logic signed [PW-1:0] mr2 [0:3];
  logic bad2, clip2;

  always_ff @(posedge clk) begin
    for (int i = 0; i < 4; i++) begin
      ma2[i] <= oa1[i] * ovn1;
      mb2[i] <= na1[i] * nvn1;
      mr2[i] <= r1 * jd1[i];
    end
    mc2[0] <= '0;
    mc2[1] <= nx1 * ps1;
    mc2[2] <= ny1 * ps1;
    mc2[3] <= '0;
    bad2 <= bad1;
    clip2 <= clip1;
  end

  // Flux stage 3: halved average term and dissipation term.
  logic signed [SAT_W-1:0] hf3 [0:3];
  logic signed [SAT_W-1:0] rr3 [0:3];
  logic bad3, clip3;

  always_ff @(posedge clk) begin
    for (int i = 0; i < 4; i++) begin
      hf3[i] <= (SAT_W'(ma2[i] >>> FRAC_BITS) + SAT_W'(mb2[i] >>> FRAC_BITS)
                + SAT_W'(mc2[i] >>> FRAC_BITS)) >>> 1;
      rr3[i] <= SAT_W'(mr2[i] >>> FRAC_BITS);
    end
    bad3 <= bad2;
    clip3 <= clip2;
  end

  // Flux stage 4: final sum, clip and status into the result register; an invalid state gives zero fluxes.
  sat_t fs [0:3];
  logic fclip;

  always_comb begin
    fclip = clip3;
    for (int i = 0; i < 4; i++) begin
      fs[i] = sat32(hf3[i] + rr3[i]);
      fclip = fclip | fs[i].clip;
    end
  end

  always_ff @(posedge clk) begin
    if (bad3) begin
      flux_mass <= '0;
      flux_mom_x <= '0;
      flux_mom_y <= '0;
      flux_energy <= '0;
      status <= ST_BAD;
    end else begin
      flux_mass <= fs[0].val;
      flux_mom_x <= fs[1].val;
      flux_mom_y <= fs[2].val;
      flux_energy <= fs[3].val;
      status <= fclip ? ST_SAT : ST_OK;
    end
  end

endmodule

`default_nettype wire

### rtl/rfx_div.sv
`default_nettype none

// Pipelined restoring divider: (num * 2^FRAC_BITS) / den, truncated toward
// zero and clipped to a word. One quotient bit per stage; den must be positive.
module rfx_div import rfx_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic  clk,
  input  word_t num,
  input  word_t den,
  output sat_t  quo
);

  localparam int NW = WORD_W + FRAC_BITS;
  localparam int ZW = WORD_W + NW;

  logic [WORD_W-1:0] mag;
  logic [ZW-1:0] z [0:NW];
  logic [WORD_W-2:0] dv [0:NW-1];
  logic neg [0:NW];
  logic [ZW-1:0] sh [1:NW];
  logic [WORD_W:0] diff [1:NW];
  logic signed [SAT_W-1:0] qm;
  logic signed [SAT_W-1:0] qs;

  // Magnitude of the dividend; the most negative word maps to 2^31.
  assign mag = num[WORD_W-1] ? (~num + 1'b1) : num;

  // Trial subtraction for every stage.
  always_comb begin
    for (int k = 1; k <= NW; k++) begin
      sh[k] = {z[k-1][ZW-2:0], 1'b0};
      diff[k] = {1'b0, sh[k][ZW-1:NW]} - {2'b00, dv[k-1]};
    end
  end

  // Load stage and quotient stages.
  always_ff @(posedge clk) begin
    z[0] <= {{WORD_W{1'b0}}, mag, {FRAC_BITS{1'b0}}};
    dv[0] <= den[WORD_W-2:0];
    neg[0] <= num[WORD_W-1];
    for (int k = 1; k <= NW; k++) begin
      if (!diff[k][WORD_W]) begin
        z[k] <= {diff[k][WORD_W-1:0], sh[k][NW-1:1], 1'b1};
      end else begin
        z[k] <= sh[k];
      end
      neg[k] <= neg[k-1];
    end
    for (int k = 1; k < NW; k++) begin
      dv[k] <= dv[k-1];
    end
  end

  // Restore the sign and clip.
  assign qm = signed'(SAT_W'(z[NW][NW-1:0]));
  assign qs = neg[NW] ? -qm : qm;

  always_ff @(posedge clk) begin
    quo <= sat32(qs);
  end

endmodule

`default_nettype wire

### rtl/rfx_side.sv
`default_nettype none

// One side of the face: velocity, pressure, normal velocity and wave speed.
module rfx_side import rfx_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic            clk,
  input  cell_t           side_in,
  input  nrm_t            nx,
  input  nrm_t            ny,
  input  logic [HR_W-1:0] heat_ratio,
  output side_t           res
);

  localparam int DL = div_lat(FRAC_BITS);
  localparam int SQ_R = (WORD_W + FRAC_BITS) / 2;
  localparam int SQ_N = 2 * SQ_R;
  localparam int HOLD = DL + SQ_R + 1;
  localparam int GM_W = (FRAC_BITS + 2 > HR_W + 1) ? FRAC_BITS + 2 : HR_W + 1;

  typedef struct packed {
    cell_t c;
    nrm_t  nx;
    nrm_t  ny;
    logic  bad;
  } sin_t;

  typedef struct packed {
    word_t p;
    word_t vn;
    logic  bad;
    logic  clip;
  } hold_t;

  sin_t dl [0:DL-1];
  sat_t u_q, v_q, c2_q;

  // Delay the state alongside the velocity dividers.
  always_ff @(posedge clk) begin
    dl[0] <= '{c: side_in, nx: nx, ny: ny,
               bad: side_in.rho[WORD_W-1] || (side_in.rho == '0)};
    for (int k = 1; k < DL; k++) begin
      dl[k] <= dl[k-1];
    end
  end

  rfx_div #(.FRAC_BITS(FRAC_BITS)) u_div_u (
    .clk (clk),
    .num (side_in.mx),
    .den (side_in.rho),
    .quo (u_q)
  );

  rfx_div #(.FRAC_BITS(FRAC_BITS)) u_div_v (
    .clk (clk),
    .num (side_in.my),
    .den (side_in.rho),
    .quo (v_q)
  );

  // Products for kinetic term and normal velocity.
  logic signed [2*WORD_W-1:0] mxu, myv;
  logic signed [WORD_W+NRM_W-1:0] unx, vny;
  word_t e2, rho2;
  logic bad2, clip2;

  always_ff @(posedge clk) begin
    mxu <= dl[DL-1].c.mx * u_q.val;
    myv <= dl[DL-1].c.my * v_q.val;
    unx <= u_q.val * dl[DL-1].nx;
    vny <= v_q.val * dl[DL-1].ny;
    e2 <= dl[DL-1].c.e;
    rho2 <= dl[DL-1].c.rho;
    bad2 <= dl[DL-1].bad;
    clip2 <= u_q.clip | v_q.clip;
  end

  // Kinetic term and normal velocity.
  sat_t kes, vns;
  word_t ke3, vn3, e3, rho3;
  logic bad3, clip3;

  assign kes = sat32(SAT_W'(mxu >>> FRAC_BITS) + SAT_W'(myv >>> FRAC_BITS));
  assign vns = sat32(SAT_W'(unx >>> FRAC_BITS) + SAT_W'(vny >>> FRAC_BITS));

  always_ff @(posedge clk) begin
    ke3 <= kes.val;
    vn3 <= vns.val;
    e3 <= e2;
    rho3 <= rho2;
    bad3 <= bad2;
    clip3 <= clip2 | kes.clip | vns.clip;
  end

  // Internal energy term.
  sat_t ins;
  word_t in4, vn4, rho4;
  logic bad4, clip4;

  assign ins = sat32(SAT_W'(e3) - SAT_W'(ke3 >>> 1));

  always_ff @(posedge clk) begin
    in4 <= ins.val;
    vn4 <= vn3;
    rho4 <= rho3;
    bad4 <= bad3;
    clip4 <= clip3 | ins.clip;
  end

  // Pressure product with gamma minus one.
  logic signed [GM_W-1:0] gm1;
  logic signed [GM_W+WORD_W-1:0] pp5;
  word_t vn5, rho5;
  logic bad5, clip5;

  assign gm1 = signed'(GM_W'(heat_ratio)) - signed'(GM_W'(1 << FRAC_BITS));

  always_ff @(posedge clk) begin
    pp5 <= gm1 * in4;
    vn5 <= vn4;
    rho5 <= rho4;
    bad5 <= bad4;
    clip5 <= clip4;
  end

  // Pressure; a negative one marks the side invalid.
  sat_t ps;
  word_t p6, vn6, rho6;
  logic bad6, clip6;

  assign ps = sat32(SAT_W'(pp5 >>> FRAC_BITS));

  always_ff @(posedge clk) begin
    p6 <= ps.val;
    vn6 <= vn5;
    rho6 <= rho5;
    bad6 <= bad5 | ps.val[WORD_W-1];
    clip6 <= clip5 | ps.clip;
  end

  // Gamma times pressure.
  logic signed [HR_W+WORD_W:0] pg7;
  word_t p7, vn7, rho7;
  logic bad7, clip7;

  always_ff @(posedge clk) begin
    pg7 <= signed'({1'b0, heat_ratio}) * p6;
    p7 <= p6;
    vn7 <= vn6;
    rho7 <= rho6;
    bad7 <= bad6;
    clip7 <= clip6;
  end

  sat_t gs;
  word_t gp8, p8, vn8, rho8;
  logic bad8, clip8;

  assign gs = sat32(SAT_W'(pg7 >>> FRAC_BITS));

  always_ff @(posedge clk) begin
    gp8 <= gs.val;
    p8 <= p7;
    vn8 <= vn7;
    rho8 <= rho7;
    bad8 <= bad7;
    clip8 <= clip7 | gs.clip;
  end

  // Squared sound speed.
  rfx_div #(.FRAC_BITS(FRAC_BITS)) u_div_c2 (
    .clk (clk),
    .num (gp8),
    .den (rho8),
    .quo (c2_q)
  );

  // Hold pressure and normal velocity over the divider and root stages.
  hold_t h [0:HOLD-1];

  always_ff @(posedge clk) begin
    h[0] <= '{p: p8, vn: vn8, bad: bad8, clip: clip8};
    for (int k = 1; k < HOLD; k++) begin
      h[k] <= h[k-1];
    end
  end

  // Pipelined square root, one root bit per stage.
  logic [SQ_R+1:0] sq_rem [0:SQ_R];
  logic [SQ_R-1:0] sq_root [0:SQ_R];
  logic [SQ_N-1:0] sq_rad [0:SQ_R];
  logic sq_clip [0:SQ_R];
  logic [SQ_R+1:0] sq_rx [1:SQ_R];
  logic [SQ_R+1:0] sq_tr [1:SQ_R];
  logic [SQ_R+2:0] sq_df [1:SQ_R];

  always_comb begin
    for (int k = 1; k <= SQ_R; k++) begin
      sq_rx[k] = {sq_rem[k-1][SQ_R-1:0], sq_rad[k-1][SQ_N-1:SQ_N-2]};
      sq_tr[k] = {sq_root[k-1], 2'b01};
      sq_df[k] = {1'b0, sq_rx[k]} - {1'b0, sq_tr[k]};
    end
  end

  always_ff @(posedge clk) begin
    sq_rem[0] <= '0;
    sq_root[0] <= '0;
    sq_rad[0] <= SQ_N'({c2_q.val[WORD_W-2:0], {FRAC_BITS{1'b0}}});
    sq_clip[0] <= c2_q.clip;
    for (int k = 1; k <= SQ_R; k++) begin
      if (!sq_df[k][SQ_R+2]) begin
        sq_rem[k] <= sq_df[k][SQ_R+1:0];
        sq_root[k] <= {sq_root[k-1][SQ_R-2:0], 1'b1};
      end else begin
        sq_rem[k] <= sq_rx[k];
        sq_root[k] <= {sq_root[k-1][SQ_R-2:0], 1'b0};
      end
      sq_rad[k] <= {sq_rad[k-1][SQ_N-3:0], 2'b00};
      sq_clip[k] <= sq_clip[k-1];
    end
  end

  // Largest wave speed of this side: |vn| plus the sound speed.
  logic signed [WORD_W:0] vnx, avn;
  sat_t ss;

  assign vnx = (WORD_W+1)'(h[HOLD-1].vn);
  assign avn = vnx[WORD_W] ? -vnx : vnx;
  assign ss = sat32(SAT_W'(avn) + signed'(SAT_W'(sq_root[SQ_R])));

  always_ff @(posedge clk) begin
    res <= '{p: h[HOLD-1].p, vn: h[HOLD-1].vn, spd: ss.val, bad: h[HOLD-1].bad,
             clip: h[HOLD-1].clip | sq_clip[SQ_R] | ss.clip};
  end

endmodule

`default_nettype wire

### rtl/rfx_chk.sv
`default_nettype none

// Port-level checks on the flux unit.
module rfx_chk import rfx_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input logic            clk,
  input logic            rst,
  input logic            start,
  input logic            busy,
  input word_t           own_density,
  input logic            done,
  input word_t           flux_mass,
  input word_t           flux_mom_x,
  input word_t           flux_mom_y,
  input word_t           flux_energy,
  input logic [ST_W-1:0] status
);

  localparam int LAT = unit_lat(FRAC_BITS);

  // Every accepted beat yields exactly one result after the fixed latency.
  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    start && !busy |-> ##LAT done)
    else $error("accepted beat gave no result");

  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, LAT))
    else $error("result without an accepted beat");

  // An invalid state gives zero fluxes.
  a_bad_zero: assert property (@(posedge clk) disable iff (rst)
    done && status == ST_BAD |->
      flux_mass == '0 && flux_mom_x == '0 && flux_mom_y == '0 && flux_energy == '0)
    else $error("invalid state with nonzero flux");

  // A non-positive owner density is always reported as invalid.
  a_bad_density: assert property (@(posedge clk) disable iff (rst)
    start && !busy && (own_density[WORD_W-1] || own_density == '0) |->
      ##LAT (done && status == ST_BAD))
    else $error("non-positive density not flagged");

endmodule

bind rusanov_flux_2d_unit rfx_chk #(.FRAC_BITS(FRAC_BITS)) u_rfx_chk (.*);

`default_nettype wire

### verif/rusanov_flux_2d_unit_tb.sv
`timescale 1ns / 100ps

module rusanov_flux_2d_unit_tb;
  import rfx_pkg::*;

  localparam int LAT = 137;
  localparam int QUIET_LIMIT = 4000;
  localparam longint ONE = 64'sd65536;
  localparam word_t W_ONE = 32'sh0001_0000;
  localparam word_t W_MAX = 32'sh7fff_ffff;
  localparam word_t W_MIN = 32'sh8000_0000;
  localparam nrm_t N_ONE = 18'sd65536;
  localparam nrm_t N_MONE = -18'sd65536;

  typedef struct {
    word_t mass;
    word_t mom_x;
    word_t mom_y;
    word_t energy;
    logic [ST_W-1:0] st;
  } flux_t;

  // One directed beat; the flux fields are used only when typed is set.
  typedef struct {
    word_t orho, omx, omy, oe, nrho, nmx, nmy, ne;
    nrm_t nx, ny;
    bit typed;
    word_t fm, fx, fy, fe;
    logic [ST_W-1:0] st;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  word_t own_density = '0, own_mom_x = '0, own_mom_y = '0, own_energy = '0;
  word_t nbr_density = '0, nbr_mom_x = '0, nbr_mom_y = '0, nbr_energy = '0;
  nrm_t normal_x = '0, normal_y = '0;
  logic heat_ratio_we = 1'b0;
  logic [HR_W-1:0] heat_ratio_wdata = '0;
  logic done;
  word_t flux_mass, flux_mom_x, flux_mom_y, flux_energy;
  logic [ST_W-1:0] status;

  flux_t flux_expected[$];
  longint gamma_q = 91750;
  bit clip_seen;
  int idle_pct = 0;
  int mismatches = 0;
  int quiet = 0;

  rusanov_flux_2d_unit dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .own_density(own_density), .own_mom_x(own_mom_x), .own_mom_y(own_mom_y),
    .own_energy(own_energy), .nbr_density(nbr_density), .nbr_mom_x(nbr_mom_x),
    .nbr_mom_y(nbr_mom_y), .nbr_energy(nbr_energy),
    .normal_x(normal_x), .normal_y(normal_y),
    .heat_ratio_we(heat_ratio_we), .heat_ratio_wdata(heat_ratio_wdata),
    .done(done), .flux_mass(flux_mass), .flux_mom_x(flux_mom_x),
    .flux_mom_y(flux_mom_y), .flux_energy(flux_energy), .status(status)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Fixed-point helpers for the flux predictor.
  function automatic longint clip32(input longint x);
    if (x > 64'sd2147483647) begin
      clip_seen = 1'b1;
      return 64'sd2147483647;
    end
    if (x < -64'sd2147483648) begin
      clip_seen = 1'b1;
      return -64'sd2147483648;
    end
    return x;
  endfunction

  function automatic longint qmul(input longint a, input longint b);
    return (a * b) >>> 16;
  endfunction

  function automatic longint qdiv(input longint a, input longint b);
    return (a * ONE) / b;
  endfunction

  function automatic longint isqrt(input longint n);
    longint r, bitv, rem;
    r = 0;
    rem = n;
    bitv = 64'sd1 <<< 62;
    while (bitv > rem) bitv = bitv >>> 2;
    while (bitv != 0) begin
      if (rem >= r + bitv) begin
        rem = rem - (r + bitv);
        r = (r >>> 1) + bitv;
      end else begin
        r = r >>> 1;
      end
      bitv = bitv >>> 2;
    end
    return r;
  endfunction

  // Primitive variables of one side; returns 0 for an unphysical state.
  function automatic bit side_eval(input longint rho, mx, my, e, nx, ny,
                                   output longint p, vn, spd);
    longint u, v, ke, inner, c2;
    p = 0;
    vn = 0;
    spd = 0;
    if (rho <= 0) return 1'b0;
    u = clip32(qdiv(mx, rho));
    v = clip32(qdiv(my, rho));
    ke = clip32(qmul(mx, u) + qmul(my, v));
    inner = clip32(e - (ke >>> 1));
    p = clip32(qmul(gamma_q - ONE, inner));
    if (p < 0) return 1'b0;
    vn = clip32(qmul(u, nx) + qmul(v, ny));
    c2 = clip32(qdiv(clip32(qmul(gamma_q, p)), rho));
    spd = clip32((vn < 0 ? -vn : vn) + isqrt(c2 <<< 16));
    return 1'b1;
  endfunction

  function automatic flux_t face_flux_predict(input face_t f);
    flux_t r;
    longint orho, omx, omy, oe, nrho, nmx, nmy, ne, nx, ny;
    longint op, ovn, ospd, np, nvn, nspd, half_spd, psum;
    bit ok_o, ok_n;
    clip_seen = 1'b0;
    orho = f.own.rho; omx = f.own.mx; omy = f.own.my; oe = f.own.e;
    nrho = f.nbr.rho; nmx = f.nbr.mx; nmy = f.nbr.my; ne = f.nbr.e;
    nx = f.nx;
    ny = f.ny;
    ok_o = side_eval(orho, omx, omy, oe, nx, ny, op, ovn, ospd);
    ok_n = side_eval(nrho, nmx, nmy, ne, nx, ny, np, nvn, nspd);
    if (!(ok_o && ok_n)) begin
      r = '{'0, '0, '0, '0, ST_BAD};
      return r;
    end
    half_spd = (ospd > nspd ? ospd : nspd) >>> 1;
    psum = op + np;
    r.mass = clip32(((qmul(orho, ovn) + qmul(nrho, nvn)) >>> 1)
                    + qmul(half_spd, orho - nrho));
    r.mom_x = clip32(((qmul(omx, ovn) + qmul(nmx, nvn) + qmul(nx, psum)) >>> 1)
                     + qmul(half_spd, omx - nmx));
    r.mom_y = clip32(((qmul(omy, ovn) + qmul(nmy, nvn) + qmul(ny, psum)) >>> 1)
                     + qmul(half_spd, omy - nmy));
    r.energy = clip32(((qmul(oe + op, ovn) + qmul(ne + np, nvn)) >>> 1)
                      + qmul(half_spd, oe - ne));
    r.st = clip_seen ? ST_SAT : ST_OK;
    return r;
  endfunction

  // Drive one face beat, with random idle cycles ahead of it.
  task automatic send_face(input face_t f, input bit typed, input flux_t want);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    own_density <= f.own.rho; own_mom_x <= f.own.mx;
    own_mom_y <= f.own.my; own_energy <= f.own.e;
    nbr_density <= f.nbr.rho; nbr_mom_x <= f.nbr.mx;
    nbr_mom_y <= f.nbr.my; nbr_energy <= f.nbr.e;
    normal_x <= f.nx;
    normal_y <= f.ny;
    do @(posedge clk); while (busy);
    flux_expected.push_back(typed ? want : face_flux_predict(f));
  endtask

  task automatic write_gamma(input logic [HR_W-1:0] g);
    start <= 1'b0;
    @(posedge clk);
    while (flux_expected.size() != 0) @(posedge clk);
    heat_ratio_we <= 1'b1;
    heat_ratio_wdata <= g;
    @(posedge clk);
    heat_ratio_we <= 1'b0;
    gamma_q = g;
  endtask

  // A random cell: mostly a physical state, sometimes raw noise.
  function automatic cell_t rand_cell();
    cell_t c;
    longint rho, u, v, mx, my, e;
    if ($urandom_range(99) < 20) begin
      c.rho = $urandom; c.mx = $urandom; c.my = $urandom; c.e = $urandom;
      return c;
    end
    rho = ($urandom_range(9) == 0) ? $urandom_range(1, 2000) :
          $urandom_range(655, 200 * 65536);
    u = longint'($urandom_range(0, 40 * 65536)) - 20 * 65536;
    v = longint'($urandom_range(0, 40 * 65536)) - 20 * 65536;
    mx = (rho * u) >>> 16;
    my = (rho * v) >>> 16;
    e = ((mx * u + my * v) >>> 17) + $urandom_range(0, 100 * 65536);
    if (e > 64'sd2147483647) e = 64'sd2147483647;
    c.rho = word_t'(rho); c.mx = word_t'(mx); c.my = word_t'(my); c.e = word_t'(e);
    // A few broken states with the sign of the density, the energy or both flipped.
    if ($urandom_range(99) < 5) c.rho = -c.rho;
    if ($urandom_range(99) < 5) c.e = -c.e;
    return c;
  endfunction

  function automatic face_t rand_face();
    face_t f;
    longint nx, ny;
    f.own = rand_cell();
    f.nbr = ($urandom_range(9) == 0) ? f.own : rand_cell();
    case ($urandom_range(9))
      0: begin
        f.nx = nrm_t'($urandom);
        f.ny = nrm_t'($urandom);
      end
      1: begin
        f.nx = nrm_t'(longint'($urandom_range(0, 131072)) - 65536);
        f.ny = nrm_t'(longint'($urandom_range(0, 131072)) - 65536);
      end
      default: begin
        nx = longint'($urandom_range(0, 131072)) - 65536;
        ny = isqrt((64'sd1 <<< 32) - nx * nx);
        if ($urandom_range(1)) ny = -ny;
        f.nx = nrm_t'(nx);
        f.ny = nrm_t'(ny);
      end
    endcase
    return f;
  endfunction

  // Check each result beat against the oldest expectation.
  always @(posedge clk) begin
    flux_t want;
    if (!rst && done) begin
      if (flux_expected.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("ERROR: result beat with nothing expected");
      end else begin
        want = flux_expected.pop_front();
        if (flux_mass !== want.mass || flux_mom_x !== want.mom_x ||
            flux_mom_y !== want.mom_y || flux_energy !== want.energy ||
            status !== want.st) begin
          mismatches++;
          if (mismatches <= 10)
            $display("ERROR: flux got %0d %0d %0d %0d st %0d, want %0d %0d %0d %0d st %0d",
                     flux_mass, flux_mom_x, flux_mom_y, flux_energy, status,
                     want.mass, want.mom_x, want.mom_y, want.energy, want.st);
        end
      end
    end
  end

  // Watchdog on cycles with no beat in either direction.
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      quiet <= 0;
    end else if (quiet >= QUIET_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  initial begin
    dir_row_t dir_rows[14];
    logic [HR_W-1:0] gammas[6];
    face_t f;
    flux_t want;

    // Directed faces at the reset gamma of 1.4.
    dir_rows = '{
      // Fluid at rest, unit density and energy: only the pressure term.
      '{W_ONE, 0, 0, W_ONE, W_ONE, 0, 0, W_ONE, N_ONE, 0,
        1, 0, 32'sd26214, 0, 0, ST_OK},
      '{W_ONE, 0, 0, W_ONE, W_ONE, 0, 0, W_ONE, 0, N_MONE,
        0, 0, 0, 0, 0, ST_OK},
      // Zero density on the owner side.
      '{0, W_ONE, W_ONE, W_ONE, W_ONE, 0, 0, W_ONE, N_ONE, 0,
        1, 0, 0, 0, 0, ST_BAD},
      // Most negative density on the neighbor side.
      '{W_ONE, 0, 0, W_ONE, W_MIN, 0, 0, W_ONE, N_ONE, 0,
        1, 0, 0, 0, 0, ST_BAD},
      // Negative energy gives negative pressure.
      '{W_ONE, 0, 0, -W_ONE, W_ONE, 0, 0, W_ONE, 0, N_ONE,
        1, 0, 0, 0, 0, ST_BAD},
      '{W_MIN, W_MIN, W_MIN, W_MIN, W_MIN, W_MIN, W_MIN, W_MIN, N_MONE, N_MONE,
        1, 0, 0, 0, 0, ST_BAD},
      '{W_MAX, W_MAX, W_MAX, W_MAX, W_MAX, W_MAX, W_MAX, W_MAX, N_ONE, N_ONE,
        0, 0, 0, 0, 0, ST_OK},
      '{W_MAX, 0, 0, W_MAX, 32'sd1, 0, 0, W_MAX, N_ONE, 0,
        0, 0, 0, 0, 0, ST_OK},
      // Tiny density with huge momentum saturates the velocity.
      '{32'sd1, W_MAX, W_MIN, W_MAX, W_ONE, 0, 0, W_ONE, 0, N_ONE,
        0, 0, 0, 0, 0, ST_OK},
      '{W_ONE, 32'sh0002_0000, -32'sh0001_8000, 32'sh000a_0000,
        32'sh0000_8000, -32'sh0000_4000, 32'sh0000_2000, 32'sh0004_0000,
        18'sd46341, -18'sd46341, 0, 0, 0, 0, 0, ST_OK},
      // Normal that is not of unit length.
      '{W_ONE, W_ONE, W_ONE, 32'sh0010_0000, W_ONE, -W_ONE, W_ONE,
        32'sh0010_0000, N_ONE, N_ONE, 0, 0, 0, 0, 0, ST_OK},
      '{32'sh0064_0000, 32'sh0c80_0000, 0, 32'sh7000_0000, W_ONE, 0, 0,
        W_ONE, N_MONE, 0, 0, 0, 0, 0, 0, ST_OK},
      '{W_ONE, 0, 0, 0, W_ONE, 0, 0, 0, N_ONE, 0,
        0, 0, 0, 0, 0, ST_OK},
      '{32'sh5555_5555, 32'shaaaa_aaaa, 32'sh5555_5555, 32'sh5555_5555,
        32'sh2aaa_aaaa, 32'sh5555_5555, 32'shaaaa_aaaa, 32'sh7555_5555,
        18'sh2aaaa, 18'sh15555, 0, 0, 0, 0, 0, ST_OK}
    };
    gammas = '{18'd65536, 18'd196608, 18'd262143, 18'd30000, 18'd91750, 18'd0};
    gammas[5] = $urandom_range(65536, 196608);

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    idle_pct = 36;
    foreach (dir_rows[i]) begin
      f.own = '{dir_rows[i].orho, dir_rows[i].omx, dir_rows[i].omy, dir_rows[i].oe};
      f.nbr = '{dir_rows[i].nrho, dir_rows[i].nmx, dir_rows[i].nmy, dir_rows[i].ne};
      f.nx = dir_rows[i].nx;
      f.ny = dir_rows[i].ny;
      want = '{dir_rows[i].fm, dir_rows[i].fx, dir_rows[i].fy, dir_rows[i].fe,
               dir_rows[i].st};
      send_face(f, dir_rows[i].typed, want);
    end

    // Random faces over several gamma settings and idle patterns.
    foreach (gammas[p]) begin
      write_gamma(gammas[p]);
      idle_pct = (p < 2) ? 36 : (p < 4) ? 53 : 0;
      repeat (215) send_face(rand_face(), 1'b0, want);
    end
    start <= 1'b0;

    while (flux_expected.size() != 0) @(posedge clk);
    repeat (LAT + 10) @(posedge clk);

    if (mismatches == 0 && flux_expected.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

### files.f
rtl/rfx_pkg.sv
rtl/rfx_div.sv
rtl/rfx_side.sv
rtl/rusanov_flux_2d_unit.sv
rtl/rfx_chk.sv
verif/rusanov_flux_2d_unit_tb.sv
